// ===== rtl/core/ima4_pkg.sv =====
// shared types, constants and the step size table for the ima4 block decoder
`timescale 1ns / 1ps
`default_nettype none

package ima4_pkg;

	// channel and block geometry
	localparam int MAX_CHANNELS = 8;
	localparam int CH_W         = 3;
	localparam int POS_W        = 6;
	localparam int BYTE_W       = 8;
	localparam int BLOCK_BYTES  = 34;

	// byte positions inside a block
	localparam logic [POS_W-1:0] POS_HDR_HIGH  = 6'd0;
	localparam logic [POS_W-1:0] POS_HDR_LOW   = 6'd1;
	localparam logic [POS_W-1:0] POS_LAST_DATA = 6'd33;

	// per channel state
	localparam int IDX_W   = 7;
	localparam int PRED_W  = 16;
	localparam int STEP_W  = 15;
	localparam int STATE_W = IDX_W + PRED_W;

	localparam logic [IDX_W-1:0] IDX_MAX       = 7'd88;
	localparam int               PRED_TOL      = 127;
	localparam int               SAMPLE_MIN    = -32768;
	localparam int               SAMPLE_MAX    = 32767;

	typedef struct packed {
		logic        [IDX_W-1:0]  idx;
		logic signed [PRED_W-1:0] pred;
	} chan_state_t;

	// standard ima step size table, indices above the top entry read as the top entry
	function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] si);
		logic [STEP_W-1:0] s;
		case (si)
			7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
			7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
			7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
			7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
			7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
			7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
			7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
			7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
			7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
			7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
			7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
			7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
			7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
			7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
			7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
			7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
			7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
			7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
			7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
			7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
			7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
			7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
			7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
			7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
			7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
			7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
			7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
			7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
			7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
			7'd87: s = 15'd29794;
			default: s = 15'd32767;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ima4_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ima4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, old data on a same address write
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/ima4_nibble.sv =====
// one adpcm nibble step: predictor update with saturation and index adaptation
`timescale 1ns / 1ps
`default_nettype none

module ima4_nibble
	import ima4_pkg::*;
(
	input  wire chan_state_t st_in,
	input  wire logic [3:0]  nib,
	output chan_state_t      st_out
);

	logic [STEP_W-1:0]  step;
	logic [STEP_W+1:0]  diff;
	logic signed [18:0] pred_ext;
	logic signed [18:0] sum;
	logic signed [7:0]  adj;
	logic signed [7:0]  idx_sum;

	// difference from the step size, shift and add
	always_comb begin
		step = step_size(st_in.idx);
		diff = {2'b00, step >> 3};
		if (nib[0]) begin
			diff = diff + {2'b00, step >> 2};
		end
		if (nib[1]) begin
			diff = diff + {2'b00, step >> 1};
		end
		if (nib[2]) begin
			diff = diff + {2'b00, step};
		end
	end

	// predictor update, saturated to 16 bits
	always_comb begin
		pred_ext = {{3{st_in.pred[PRED_W-1]}}, st_in.pred};
		if (nib[3]) begin
			sum = pred_ext - $signed({2'b00, diff});
		end else begin
			sum = pred_ext + $signed({2'b00, diff});
		end
		if (sum < 19'(SAMPLE_MIN)) begin
			st_out.pred = PRED_W'(SAMPLE_MIN);
		end else if (sum > 19'(SAMPLE_MAX)) begin
			st_out.pred = PRED_W'(SAMPLE_MAX);
		end else begin
			st_out.pred = sum[PRED_W-1:0];
		end
	end

	// index adaptation, clamped to the table range
	always_comb begin
		if (nib[2]) begin
			adj = $signed({5'b00000, nib[1:0], 1'b0}) + 8'sd2;
		end else begin
			adj = -8'sd1;
		end
		idx_sum = $signed({1'b0, st_in.idx}) + adj;
		if (idx_sum < 8'sd0) begin
			st_out.idx = '0;
		end else if (idx_sum > $signed({1'b0, IDX_MAX})) begin
			st_out.idx = IDX_MAX;
		end else begin
			st_out.idx = idx_sum[IDX_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ima_adpcm_qt_block_decoder.sv =====
// top level of the quicktime ima4 adpcm block decoder
//
// Usage: block bytes enter on the s_ channel, one item per byte. s_tuser
// carries the channel, s_tdata the position in the 34-byte block and the
// raw byte. Positions 0 and 1 are the header word and give no result;
// positions 2 to 33 each give one result item on the m_ channel holding
// two 16-bit samples (low nibble first), tuser the channel and tlast set
// for position 33. Positions 34 and above are dropped.
// Throughput is one item per cycle while s_tready is high. The state
// memory is read synchronously as an item enters the decode stage, which
// updates the channel state and writes it back while loading the output
// register. A write to the channel read in the same cycle is forwarded
// into the decode stage.
// Reset clears the per channel state through valid bits (an unwritten
// channel reads as predictor 0, index 0), the shared header byte and all
// handshake state; no clearing pass is needed.
// When the receiver stalls, the output register holds its item and the
// decode stage holds the next one; s_tready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module ima_adpcm_qt_block_decoder
	import ima4_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input byte channel
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // byte_index[5:0], data_byte[13:6], zero[15:14]
	input  wire logic [2:0]  s_tuser,   // channel[2:0]
	// decoded sample channel
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // sample_first[15:0], sample_second[31:16]
	output logic [2:0]       m_tuser,   // out_channel[2:0]
	output logic             m_tlast    // last_in_block
);

	// decode stage
	logic              valid_s1;
	logic [CH_W-1:0]   ch_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [BYTE_W-1:0] byte_s1;

	// shared header byte, valid bits, forwarding register
	logic [BYTE_W-1:0]       hdr_high_q;
	logic [MAX_CHANNELS-1:0] ent_valid_q;
	logic                    fwd_valid_q;
	logic [CH_W-1:0]         fwd_ch_q;
	chan_state_t             fwd_state_q;

	// output register
	logic              out_valid_q;
	logic [CH_W-1:0]   out_ch_q;
	logic [PRED_W-1:0] out_first_q;
	logic [PRED_W-1:0] out_second_q;
	logic              out_last_q;

	// memory port
	logic            ram_we;
	logic [CH_W-1:0] ram_raddr;
	logic [STATE_W-1:0] ram_rdata;
	chan_state_t     ram_wstate;

	logic        in_range;
	logic        is_hdr_high;
	logic        is_hdr_low;
	logic        is_data;
	logic        res_s1;
	logic        adv;
	chan_state_t cur_state;
	chan_state_t mid_state;
	chan_state_t end_state;
	chan_state_t hdr_state;

	logic [15:0]              hdr_word;
	logic signed [PRED_W-1:0] hdr_pred;
	logic [IDX_W-1:0]         hdr_idx;
	logic signed [PRED_W:0]   pred_diff;
	logic [PRED_W:0]          pred_dist;
	logic                     reload;

	// classify the item in the decode stage
	always_comb begin
		in_range    = (pos_s1 < POS_W'(BLOCK_BYTES))
			&& ({1'b0, ch_s1} < (CH_W + 1)'(MAX_CHANNELS));
		is_hdr_high = in_range && (pos_s1 == POS_HDR_HIGH);
		is_hdr_low  = in_range && (pos_s1 == POS_HDR_LOW);
		is_data     = in_range && !is_hdr_high && !is_hdr_low;
		res_s1      = valid_s1 && is_data;
		adv         = !res_s1 || !out_valid_q || m_tready;
	end

	assign s_tready  = adv;
	assign ram_raddr = adv ? s_tuser : ch_s1;

	// current channel state: forwarded write, memory, or reset value
	always_comb begin
		if (fwd_valid_q && (fwd_ch_q == ch_s1)) begin
			cur_state = fwd_state_q;
		end else if (ent_valid_q[ch_s1]) begin
			cur_state = chan_state_t'(ram_rdata);
		end else begin
			cur_state = '0;
		end
	end

	// header reload rule
	always_comb begin
		hdr_word  = {hdr_high_q, byte_s1};
		hdr_pred  = $signed({hdr_word[15:7], 7'b0000000});
		hdr_idx   = hdr_word[IDX_W-1:0];
		pred_diff = $signed({cur_state.pred[PRED_W-1], cur_state.pred})
			- $signed({hdr_pred[PRED_W-1], hdr_pred});
		pred_dist = pred_diff[PRED_W] ? (PRED_W + 1)'(-pred_diff) : pred_diff;
		reload    = (cur_state.idx != hdr_idx) || (pred_dist > (PRED_W + 1)'(PRED_TOL));
		hdr_state = cur_state;
		if (reload) begin
			hdr_state.pred = hdr_pred;
			hdr_state.idx  = (hdr_idx > IDX_MAX) ? IDX_MAX : hdr_idx;
		end
	end

	// two chained nibble steps, low nibble first
	ima4_nibble u_nib_low (
		.st_in  (cur_state),
		.nib    (byte_s1[3:0]),
		.st_out (mid_state)
	);

	ima4_nibble u_nib_high (
		.st_in  (mid_state),
		.nib    (byte_s1[7:4]),
		.st_out (end_state)
	);

	// write back
	always_comb begin
		ram_we     = valid_s1 && adv && (is_hdr_low || is_data);
		ram_wstate = is_hdr_low ? hdr_state : end_state;
	end

	ima4_ram #(
		.WIDTH (STATE_W),
		.DEPTH (MAX_CHANNELS),
		.ADDR_W(CH_W)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ch_s1),
		.wdata (ram_wstate),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			hdr_high_q  <= '0;
			ent_valid_q <= '0;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= ram_we;
			if (adv) begin
				valid_s1 <= s_tvalid;
			end
			if (valid_s1 && adv && is_hdr_high) begin
				hdr_high_q <= byte_s1;
			end
			if (ram_we) begin
				ent_valid_q[ch_s1] <= 1'b1;
			end
			if (adv && res_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s1   <= s_tuser;
			pos_s1  <= s_tdata[POS_W-1:0];
			byte_s1 <= s_tdata[POS_W +: BYTE_W];
		end
		if (ram_we) begin
			fwd_ch_q    <= ch_s1;
			fwd_state_q <= ram_wstate;
		end
		if (adv && res_s1) begin
			out_ch_q     <= ch_s1;
			out_first_q  <= mid_state.pred;
			out_second_q <= end_state.pred;
			out_last_q   <= (pos_s1 == POS_LAST_DATA);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_second_q, out_first_q};
	assign m_tuser  = out_ch_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/ima4_checker.sv =====
// port level checks for the ima4 block decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ima4_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [15:0] s_tdata,
	input wire logic [2:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [2:0]  m_tuser,
	input wire logic        m_tlast
);

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output item changed");

	// with the output register empty the input side is never stalled
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output empty");

	// a fresh result follows an accepted data byte at positions 2 to 33
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tdata[5:0] >= 6'd2)
			&& (s_tdata[5:0] < 6'd34), 2))
		else $error("result without a matching data byte");

	// the last flag follows the position of that byte, the channel tag its channel
	a_last_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (m_tlast == $past(s_tdata[5:0] == 6'd33, 2))
			&& (m_tuser == $past(s_tuser, 2)))
		else $error("result tags do not match the source byte");

endmodule

bind ima_adpcm_qt_block_decoder ima4_checker u_ima4_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
